// ----- rtl/bwth_pkg.sv -----
// Shared types, constants and the weight table of the bit-walk XOR hash.
`default_nettype none
package bwth_pkg;

	localparam int ByteW    = 8;
	localparam int DigestW  = 11;
	localparam int PosW     = 6;
	localparam int TableLen = 35;

	localparam logic [PosW-1:0] PosFirst = '0;
	localparam logic [PosW-1:0] PosLast  = PosW'(TableLen - 1);

	typedef logic [ByteW-1:0]   byte_t;
	typedef logic [DigestW-1:0] digest_t;
	typedef logic [PosW-1:0]    pos_t;

	// Result handed from the walker to the output register
	typedef struct packed {
		logic    valid;
		digest_t digest;
	} emit_t;

	// Weight table, one word per pointer position
	function automatic digest_t weight_word(input pos_t pos);
		digest_t w;
		case (pos)
			6'd0:    w = 11'd3;
			6'd1:    w = 11'd5;
			6'd2:    w = 11'd9;
			6'd3:    w = 11'd17;
			6'd4:    w = 11'd32;
			6'd5:    w = 11'd36;
			6'd6:    w = 11'd40;
			6'd7:    w = 11'd50;
			6'd8:    w = 11'd64;
			6'd9:    w = 11'd66;
			6'd10:   w = 11'd72;
			6'd11:   w = 11'd84;
			6'd12:   w = 11'd128;
			6'd13:   w = 11'd132;
			6'd14:   w = 11'd138;
			6'd15:   w = 11'd144;
			6'd16:   w = 11'd193;
			6'd17:   w = 11'd256;
			6'd18:   w = 11'd258;
			6'd19:   w = 11'd260;
			6'd20:   w = 11'd280;
			6'd21:   w = 11'd416;
			6'd22:   w = 11'd512;
			6'd23:   w = 11'd514;
			6'd24:   w = 11'd524;
			6'd25:   w = 11'd528;
			6'd26:   w = 11'd545;
			6'd27:   w = 11'd832;
			6'd28:   w = 11'd1024;
			6'd29:   w = 11'd1030;
			6'd30:   w = 11'd1032;
			6'd31:   w = 11'd1040;
			6'd32:   w = 11'd1120;
			6'd33:   w = 11'd1281;
			6'd34:   w = 11'd1664;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/bwth_walk.sv -----
// Bit-serial walker: shifts a word out LSB first, steps the pointer and folds in table words.
`default_nettype none
module bwth_walk (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire bwth_pkg::byte_t load_byte,
	input  wire logic           load_last,
	input  wire logic           out_free,
	output      logic           stall,
	output      bwth_pkg::emit_t emit
);
	import bwth_pkg::*;

	logic    busy_q;
	logic    last_q;
	byte_t   shift_q;
	pos_t    pos_q;
	digest_t acc_q;

	logic    step;
	logic    rest_zero;
	logic    done;
	pos_t    pos_nx;
	digest_t acc_nx;

	// Move the pointer one place by the current bit and fold in its word
	always_comb begin
		if (shift_q[0]) begin
			pos_nx = (pos_q == PosLast) ? PosFirst : pos_q + 1'b1;
		end else begin
			pos_nx = (pos_q == PosFirst) ? PosLast : pos_q - 1'b1;
		end
		acc_nx = acc_q ^ weight_word(pos_nx);
	end

	// Finish once no set bit is left after this cycle's step and, on the last word, the output has room
	assign step      = busy_q && (shift_q != '0);
	assign rest_zero = (shift_q[ByteW-1:1] == '0);
	assign done      = busy_q && rest_zero && (!last_q || out_free);
	assign stall     = busy_q && !done;

	assign emit.valid  = done && last_q;
	assign emit.digest = step ? acc_nx : acc_q;

	// Advance the walk; clear state after the digest leaves; load the next word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			last_q  <= 1'b0;
			shift_q <= '0;
			pos_q   <= PosFirst;
			acc_q   <= '0;
		end else begin
			if (step) begin
				pos_q   <= pos_nx;
				acc_q   <= acc_nx;
				shift_q <= shift_q >> 1;
			end
			if (done) begin
				busy_q <= 1'b0;
			end
			if (emit.valid) begin
				pos_q <= PosFirst;
				acc_q <= '0;
			end
			if (load) begin
				busy_q  <= 1'b1;
				last_q  <= load_last;
				shift_q <= load_byte;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/bitwalk_table_xor_hash.sv -----
// Bit-walk XOR hash: top level with the walker and the digest output register.
// The walker handles one bit per cycle, LSB first, up to the byte's highest set bit (a zero byte
// needs no step); no new word is taken before it ends, and the last byte waits for output room.
// The next word is taken in the walker's final cycle; the digest appears in the cycle after it.
// Reset clears the pointer, the accumulator, the walker and the output valid flag.
`default_nettype none
module bitwalk_table_xor_hash (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             data_valid,
	output      logic             data_stall,
	input  wire bwth_pkg::byte_t   data_byte,
	input  wire logic             last_byte,
	output      logic             digest_valid,
	input  wire logic             digest_stall,
	output      bwth_pkg::digest_t digest
);
	import bwth_pkg::*;

	logic    out_valid_q;
	digest_t digest_q;
	logic    out_free;
	logic    walk_stall;
	logic    data_accept;
	emit_t   emit;

	assign out_free    = !out_valid_q || !digest_stall;
	assign data_stall  = walk_stall;
	assign data_accept = data_valid && !walk_stall;

	bwth_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (data_accept),
		.load_byte (data_byte),
		.load_last (last_byte),
		.out_free  (out_free),
		.stall     (walk_stall),
		.emit      (emit)
	);

	// Hold the digest until taken; refill when the register frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			digest_q <= emit.digest;
		end
	end

	assign digest_valid = out_valid_q;
	assign digest       = digest_q;

	// The walker only finishes a message when the output register can take it
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> (!out_valid_q || !digest_stall))
		else $error("digest emitted while output register full");

	// An emitted digest shows up on the port in the next cycle
	a_emit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |=> (digest_valid && digest == $past(emit.digest)))
		else $error("emitted digest not presented");

endmodule
`default_nettype wire
